FILE: rtl/matrix_multiply_engine_defines.svh
// Assertion macros used by the engine RTL.
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define MME_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define MME_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MME_ASSERT_IMP(lbl, ante, cons)
`define MME_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/mme_pkg.sv
package mme_pkg;

  localparam int unsigned MAX_DIM_DEFAULT    = 8;
  localparam int unsigned ELEM_WIDTH_DEFAULT = 32;
  localparam int unsigned FRAC_BITS          = 16;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned VALUE_W = 32;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 4;

  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_OF_A  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_OF_B  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [INDEX_W-1:0]        row_index;
    logic [INDEX_W-1:0]        col_index;
    logic signed [VALUE_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        out_row;
    logic [INDEX_W-1:0]        out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      overflowed;
    logic                      last;
  } out_item_t;

endpackage

FILE: rtl/mme_stream_if.sv
interface mme_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/matrix_multiply_engine.sv
// channel   dir  payload      accepted when
// operand   in   in_item_t    operand.valid && operand.ready
// result    out  out_item_t   result.valid && result.ready
// cfg_*     in   4-bit data   cfg_write high
//
// A write item is stored as it is accepted. A compute item runs over
// all rows*cols result elements: each result element reads its inner
// operands from the two stores, one pair per cycle, through a read, a
// multiply and an accumulate stage, then waits for the output register.
// Reset is synchronous; the stores are not cleared. A stalled result
// holds the sequencer in its finishing state; no item is taken until
// the last result is loaded.
`include "matrix_multiply_engine_defines.svh"

module matrix_multiply_engine #(
  parameter int unsigned MAX_DIM    = mme_pkg::MAX_DIM_DEFAULT,
  parameter int unsigned ELEM_WIDTH = mme_pkg::ELEM_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mme_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mme_pkg::CFG_DATA_W-1:0]     cfg_data,
  mme_stream_if.sink                         operand,
  mme_stream_if.source                       result
);
  import mme_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned PROD_W = 2 * ELEM_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + IDX_W + 1;

  localparam logic signed [ELEM_WIDTH-1:0] SAT_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic signed [ELEM_WIDTH-1:0] SAT_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]      ACC_MAX = ACC_W'(SAT_MAX);
  localparam logic signed [ACC_W-1:0]      ACC_MIN = ACC_W'(SAT_MIN);
  localparam logic signed [VALUE_W-1:0]    OUT_MAX = VALUE_W'(SAT_MAX);
  localparam logic signed [VALUE_W-1:0]    OUT_MIN = VALUE_W'(SAT_MIN);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_FINISH} state_t;

  function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_DATA_W-1:0] r);
    if (r == '0) return DIM_W'(1);
    if (r > MAX_DIM) return DIM_W'(MAX_DIM);
    return DIM_W'(r);
  endfunction

  // configuration
  logic [CFG_DATA_W-1:0] rows_of_a, inner_size, cols_of_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_a  <= DIM_RESET;
      inner_size <= DIM_RESET;
      cols_of_b  <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS_OF_A:  rows_of_a  <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_COLS_OF_B:  cols_of_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] nl, nm, nn;
  assign nl = dim_of(rows_of_a);
  assign nm = dim_of(inner_size);
  assign nn = dim_of(cols_of_b);

  // sequencer
  state_t          state;
  logic [IDX_W-1:0] i, j, k;
  logic            out_valid;
  out_item_t       out_data;

  logic                  accept, start, wr_ok, a_we, b_we, out_free, load;
  logic                  last_k, last_elem, acc_done;
  logic [ADDR_W-1:0]     waddr, ra, rb;
  logic signed [ELEM_WIDTH-1:0] wdata;
  logic signed [ACC_W-1:0]      acc, shifted;
  logic signed [ELEM_WIDTH-1:0] sat_val;
  logic                         sat_ovf;

  assign operand.ready = (state == ST_IDLE);
  assign accept = operand.valid && operand.ready;
  assign start  = accept && (operand.payload.operation == OP_COMPUTE);
  assign wr_ok  = (operand.payload.row_index < MAX_DIM) &&
                  (operand.payload.col_index < MAX_DIM);
  assign a_we   = accept && wr_ok && (operand.payload.operation == OP_WRITE_A);
  assign b_we   = accept && wr_ok && (operand.payload.operation == OP_WRITE_B);
  assign waddr  = ADDR_W'(operand.payload.row_index * MAX_DIM + operand.payload.col_index);
  assign wdata  = operand.payload.element_value[ELEM_WIDTH-1:0];

  assign ra = ADDR_W'(i * MAX_DIM + k);
  assign rb = ADDR_W'(k * MAX_DIM + j);

  assign last_k    = (DIM_W'(k) + DIM_W'(1)) == nm;
  assign last_elem = ((DIM_W'(i) + DIM_W'(1)) == nl) && ((DIM_W'(j) + DIM_W'(1)) == nn);
  assign out_free  = !out_valid || result.ready;
  assign load      = (state == ST_FINISH) && out_free;

  // floor shift back to Q16.16, then saturate to the element width
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    sat_ovf = 1'b0;
    sat_val = shifted[ELEM_WIDTH-1:0];
    if (shifted > ACC_MAX) begin
      sat_val = SAT_MAX;
      sat_ovf = 1'b1;
    end else if (shifted < ACC_MIN) begin
      sat_val = SAT_MIN;
      sat_ovf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_k) begin
            k     <= '0;
            state <= ST_WAIT;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (acc_done) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data.out_row    <= INDEX_W'(i);
            out_data.out_col    <= INDEX_W'(j);
            out_data.out_value  <= VALUE_W'(sat_val);
            out_data.overflowed <= sat_ovf;
            out_data.last       <= last_elem;
            if (last_elem) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_RUN;
              if ((DIM_W'(j) + DIM_W'(1)) == nn) begin
                j <= '0;
                i <= i + IDX_W'(1);
              end else begin
                j <= j + IDX_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

  // operand stores; writes only while idle, registered reads every cycle,
  // of which only those issued while running reach the accumulator
  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] b_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] a_q, b_q;

  always_ff @(posedge clk) begin
    if (a_we) a_mem[waddr] <= wdata;
    a_q <= a_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[waddr] <= wdata;
    b_q <= b_mem[rb];
  end

  // read -> multiply -> accumulate
  logic rd_v, rd_last, mul_v, mul_last;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v     <= 1'b0;
      rd_last  <= 1'b0;
      mul_v    <= 1'b0;
      mul_last <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      rd_v     <= (state == ST_RUN);
      rd_last  <= (state == ST_RUN) && last_k;
      mul_v    <= rd_v;
      mul_last <= rd_last;
      acc_done <= mul_v && mul_last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_q * b_q;
    if (start || load) acc <= '0;
    else if (mul_v) acc <= acc + ACC_W'(prod);
  end

  `MME_ASSERT_IMP(a_idle_pipe_empty, operand.ready, !rd_v && !mul_v && !acc_done)
  `MME_ASSERT_IMP(a_done_in_wait, acc_done, state == ST_WAIT)
  `MME_ASSERT_NXT(a_last_to_idle, load && last_elem, state == ST_IDLE && out_valid)
  `MME_ASSERT_IMP(a_ovf_saturates, result.valid && result.payload.overflowed,
                  result.payload.out_value == OUT_MAX || result.payload.out_value == OUT_MIN)

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import mme_pkg::*;

  localparam int unsigned MAX_DIM = MAX_DIM_DEFAULT;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 100;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD = 300;
  localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
  localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

  typedef struct {
    bit                    is_dims;
    logic [CFG_DATA_W-1:0] r, k, c;
    in_item_t              item;
    bit                    typed;
    out_item_t             want;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mme_stream_if #(.item_t(in_item_t))  operand_ch ();
  mme_stream_if #(.item_t(out_item_t)) result_ch ();

  matrix_multiply_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .operand   (operand_ch),
    .result    (result_ch)
  );

  // shadow of the block: dimension registers and both operand stores
  logic [CFG_DATA_W-1:0] dim_rows  = DIM_RESET;
  logic [CFG_DATA_W-1:0] dim_inner = DIM_RESET;
  logic [CFG_DATA_W-1:0] dim_cols  = DIM_RESET;
  logic signed [VALUE_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [VALUE_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  bit a_seen [MAX_DIM*MAX_DIM];
  bit b_seen [MAX_DIM*MAX_DIM];
  out_item_t c_due [$];

  int n_bad = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 51;
  bit long_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_bad(string msg);
    if (n_bad < 40) $display("%0t ns: %s", $time, msg);
    n_bad++;
  endtask

  function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [INDEX_W-1:0] row,
                                         logic [INDEX_W-1:0] col, logic [VALUE_W-1:0] val);
    in_item_t it;
    it.operation     = op;
    it.row_index     = row;
    it.col_index     = col;
    it.element_value = val;
    return it;
  endfunction

  // writes fill the stores; a compute queues every C element, row-major
  function automatic void product_step(in_item_t it);
    int unsigned nr, nk, nc;
    int i, j, k;
    logic signed [71:0] acc;
    out_item_t elem;
    case (it.operation)
      OP_WRITE_A: begin
        a_mem[{it.row_index, it.col_index}]  = it.element_value;
        a_seen[{it.row_index, it.col_index}] = 1'b1;
      end
      OP_WRITE_B: begin
        b_mem[{it.row_index, it.col_index}]  = it.element_value;
        b_seen[{it.row_index, it.col_index}] = 1'b1;
      end
      OP_COMPUTE: begin
        nr = eff_dim(dim_rows);
        nk = eff_dim(dim_inner);
        nc = eff_dim(dim_cols);
        for (i = 0; i < nr; i++) begin
          for (j = 0; j < nc; j++) begin
            acc = '0;
            for (k = 0; k < nk; k++)
              acc = acc + a_mem[i*MAX_DIM + k] * b_mem[k*MAX_DIM + j];
            // arithmetic shift floors toward minus infinity
            acc = acc >>> FRAC_BITS;
            elem.out_row    = 3'(i);
            elem.out_col    = 3'(j);
            elem.overflowed = (acc > Q_MAX) || (acc < Q_MIN);
            elem.out_value  = (acc > Q_MAX) ? 32'h7FFF_FFFF :
                              (acc < Q_MIN) ? 32'h8000_0000 : acc[31:0];
            elem.last       = (i == nr - 1) && (j == nc - 1);
            c_due.push_back(elem);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      1, 2: return $urandom;
      3, 4, 5, 6: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
      default: return $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(9))
      0: return 4'd0;
      1: return 4'd15;
      2: return 4'd8;
      default: return 4'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic step_t dims_row(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] k,
                                     logic [CFG_DATA_W-1:0] c);
    step_t s;
    s.is_dims = 1'b1;
    s.r = r;
    s.k = k;
    s.c = c;
    s.item = '0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t item_row(logic [OP_W-1:0] op, logic [INDEX_W-1:0] row,
                                     logic [INDEX_W-1:0] col, logic [VALUE_W-1:0] val);
    step_t s;
    s.is_dims = 1'b0;
    s.r = '0;
    s.k = '0;
    s.c = '0;
    s.item = make_item(op, row, col, val);
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  // 1x1x1 compute whose single element is known by inspection
  function automatic step_t typed_row(logic [VALUE_W-1:0] val, logic ovf);
    step_t s;
    s = item_row(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
    s.typed = 1'b1;
    s.want.out_row = 3'd0;
    s.want.out_col = 3'd0;
    s.want.out_value = val;
    s.want.overflowed = ovf;
    s.want.last = 1'b1;
    return s;
  endfunction

  task automatic drive_operand(in_item_t it, bit typed, out_item_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_ch.valid <= 1'b0;
      @(posedge clk);
    end
    operand_ch.valid   <= 1'b1;
    operand_ch.payload <= it;
    @(posedge clk);
    while (!operand_ch.ready) @(posedge clk);
    if (typed) c_due.push_back(want);
    else product_step(it);
  endtask

  // drain outstanding C elements, then let trailing writes retire
  task automatic settle();
    operand_ch.valid <= 1'b0;
    while (c_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_dims(logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] k,
                          logic [CFG_DATA_W-1:0] c);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROWS_OF_A;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= REG_INNER_SIZE;
    cfg_data  <= k;
    @(posedge clk);
    cfg_index <= REG_COLS_OF_B;
    cfg_data  <= c;
    @(posedge clk);
    cfg_write <= 1'b0;
    dim_rows  = r;
    dim_inner = k;
    dim_cols  = c;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (c_due.size() == 0) begin
        note_bad($sformatf("stray result C[%0d][%0d] = %h", result_ch.payload.out_row,
                           result_ch.payload.out_col, result_ch.payload.out_value));
      end else begin
        want = c_due.pop_front();
        if (result_ch.payload.out_row !== want.out_row)
          note_bad($sformatf("row %0d, expected %0d", result_ch.payload.out_row,
                             want.out_row));
        if (result_ch.payload.out_col !== want.out_col)
          note_bad($sformatf("col %0d, expected %0d", result_ch.payload.out_col,
                             want.out_col));
        if (result_ch.payload.out_value !== want.out_value)
          note_bad($sformatf("C[%0d][%0d] value %h, expected %h", want.out_row,
                             want.out_col, result_ch.payload.out_value, want.out_value));
        if (result_ch.payload.overflowed !== want.overflowed)
          note_bad($sformatf("C[%0d][%0d] overflow %b, expected %b", want.out_row,
                             want.out_col, result_ch.payload.overflowed, want.overflowed));
        if (result_ch.payload.last !== want.last)
          note_bad($sformatf("C[%0d][%0d] last %b, expected %b", want.out_row,
                             want.out_col, result_ch.payload.last, want.last));
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      // long hold: the engine backs up and stops taking items
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    step_t steps [$];
    in_item_t batch [$];
    int ph, rand_items, nr, nk, nc, i, j, k, pos, guard;

    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    operand_ch.valid <= 1'b0;
    operand_ch.payload <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    steps.push_back(dims_row(4'd1, 4'd1, 4'd1));
    steps.push_back(item_row(OP_WRITE_A, 3'd0, 3'd0, 32'h0001_0000));
    steps.push_back(item_row(OP_WRITE_B, 3'd0, 3'd0, 32'h0001_0000));
    steps.push_back(typed_row(32'h0001_0000, 1'b0));
    steps.push_back(item_row(OP_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
    steps.push_back(item_row(OP_WRITE_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
    steps.push_back(typed_row(32'h7FFF_FFFF, 1'b1));
    steps.push_back(item_row(OP_WRITE_B, 3'd0, 3'd0, 32'h8000_0000));
    steps.push_back(typed_row(32'h8000_0000, 1'b1));
    steps.push_back(item_row(OP_WRITE_A, 3'd0, 3'd0, 32'h8000_0000));
    steps.push_back(typed_row(32'h7FFF_FFFF, 1'b1));
    // most negative value times 1.0 lands exactly on the bound
    steps.push_back(item_row(OP_WRITE_B, 3'd0, 3'd0, 32'h0001_0000));
    steps.push_back(typed_row(32'h8000_0000, 1'b0));
    // smallest negative times smallest positive floors to -1 lsb
    steps.push_back(item_row(OP_WRITE_A, 3'd0, 3'd0, 32'hFFFF_FFFF));
    steps.push_back(item_row(OP_WRITE_B, 3'd0, 3'd0, 32'h0000_0001));
    steps.push_back(typed_row(32'hFFFF_FFFF, 1'b0));
    steps.push_back(item_row(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF));
    steps.push_back(item_row(OP_WRITE_A, 3'd7, 3'd7, 32'h1234_5678));
    steps.push_back(dims_row(4'd2, 4'd1, 4'd2));
    steps.push_back(item_row(OP_WRITE_A, 3'd1, 3'd0, 32'hFFFE_8000));
    steps.push_back(item_row(OP_WRITE_B, 3'd0, 3'd1, 32'h0002_8000));
    steps.push_back(item_row(OP_COMPUTE, 3'd0, 3'd0, 32'h0));

    foreach (steps[s]) begin
      if (steps[s].is_dims) begin
        settle();
        set_dims(steps[s].r, steps[s].k, steps[s].c);
      end else begin
        drive_operand(steps[s].item, steps[s].typed, steps[s].want);
      end
    end

    // random phases: at times reshape, load unseen and some seen operands, compute
    ph = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 51;
      end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // the phase after the long hold keeps its shape so items queue up behind it
      if (ph < 4 || (ph != 4 && $urandom_range(2) == 0)) begin
        settle();
        case (ph)
          0: set_dims(4'd15, 4'd0, 4'd15);
          1: set_dims(4'd0, 4'd15, 4'd0);
          2: set_dims(4'd8, 4'd1, 4'd8);
          3: set_dims(4'd3, 4'd2, 4'd3);
          default: set_dims(pick_dim(), pick_dim(), pick_dim());
        endcase
      end
      nr = eff_dim(dim_rows);
      nk = eff_dim(dim_inner);
      nc = eff_dim(dim_cols);
      batch.delete();
      for (i = 0; i < nr; i++)
        for (k = 0; k < nk; k++)
          if (!a_seen[i*MAX_DIM + k] || $urandom_range(1) == 1)
            batch.push_back(make_item(OP_WRITE_A, 3'(i), 3'(k), pick_value()));
      for (k = 0; k < nk; k++)
        for (j = 0; j < nc; j++)
          if (!b_seen[k*MAX_DIM + j] || $urandom_range(1) == 1)
            batch.push_back(make_item(OP_WRITE_B, 3'(k), 3'(j), pick_value()));
      repeat ($urandom_range(3)) begin
        pos = $urandom_range(batch.size());
        batch.insert(pos, make_item($urandom_range(1) ? OP_WRITE_A : OP_WRITE_B,
                                    3'($urandom_range(7)), 3'($urandom_range(7)),
                                    pick_value()));
      end
      if ($urandom_range(3) == 0) begin
        pos = $urandom_range(batch.size());
        batch.insert(pos, make_item(OP_UNUSED, 3'($urandom), 3'($urandom), $urandom));
      end
      batch.push_back(make_item(OP_COMPUTE, 3'($urandom), 3'($urandom), $urandom));
      if (ph == 3) long_hold_req = 1'b1;
      foreach (batch[b]) begin
        drive_operand(batch[b], 1'b0, '0);
        if (batch[b].operation != OP_UNUSED) rand_items++;
      end
      ph++;
    end

    operand_ch.valid <= 1'b0;
    for (guard = 0; guard < 100_000 && c_due.size() != 0; guard++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (c_due.size() != 0)
      note_bad($sformatf("%0d result items never arrived", c_due.size()));

    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
